>>> rtl/rstv_pkg.sv
// rstv_pkg: shared types, constants and register codes for the RC stick to
// velocity mapper. No dependencies.
`timescale 1ns / 1ps

package rstv_pkg;

   localparam int CHAN_BITS     = 11;
   localparam int TOL_BITS      = 8;
   localparam int VEL_BITS      = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [CHAN_BITS-1:0]       chan_type;
   typedef logic [TOL_BITS-1:0]        tol_type;
   typedef logic signed [VEL_BITS-1:0] vel_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_CHAN_MIN       = 3'd0,
      CSR_CHAN_MAX       = 3'd1,
      CSR_TOLERANCE      = 3'd2,
      CSR_LINEAR_GAIN    = 3'd3,
      CSR_LINEAR_OFFSET  = 3'd4,
      CSR_ANGULAR_GAIN   = 3'd5,
      CSR_ANGULAR_OFFSET = 3'd6
   } csr_addr_type;

   localparam chan_type RST_CHAN_MIN       = CHAN_BITS'(970);
   localparam chan_type RST_CHAN_MAX       = CHAN_BITS'(1990);
   localparam tol_type  RST_TOLERANCE      = '0;
   localparam vel_type  RST_LINEAR_GAIN    = 32'sd49345;
   localparam vel_type  RST_LINEAR_OFFSET  = -32'sd73030234;
   localparam vel_type  RST_ANGULAR_GAIN   = 32'sd32897;
   localparam vel_type  RST_ANGULAR_OFFSET = -32'sd48686832;

   typedef struct packed {
      chan_type chan_min;
      chan_type chan_max;
      tol_type  tolerance;
      vel_type  linear_gain;
      vel_type  linear_offset;
      vel_type  angular_gain;
      vel_type  angular_offset;
   } cfg_type;

   typedef struct packed {
      chan_type left_vertical;
      chan_type left_horizontal;
      chan_type right_vertical;
      chan_type right_horizontal;
      chan_type left_arm_switch;
      chan_type right_arm_switch;
      chan_type left_mode_switch;
      chan_type right_mode_switch;
   } frame_type;

   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_LINEAR,
      SEL_ANGULAR,
      SEL_BOTH,
      SEL_HOLD
   } sel_type;

   typedef struct packed {
      sel_type  sel;
      logic     left_active;
      logic     right_active;
      logic     arm_conflict;
      chan_type vert_x;
      chan_type horiz_x;
   } dec_type;

endpackage

>>> rtl/rstv_req_if.sv
// rstv_req_if: input channel carrying one RC frame of eight pulse widths.
// Depends on rstv_pkg.
`timescale 1ns / 1ps

interface rstv_req_if;
   logic               valid;
   logic               ready;
   rstv_pkg::chan_type left_vertical;
   rstv_pkg::chan_type left_horizontal;
   rstv_pkg::chan_type right_vertical;
   rstv_pkg::chan_type right_horizontal;
   rstv_pkg::chan_type left_arm_switch;
   rstv_pkg::chan_type right_arm_switch;
   rstv_pkg::chan_type left_mode_switch;
   rstv_pkg::chan_type right_mode_switch;

   modport source (
      output valid, left_vertical, left_horizontal, right_vertical, right_horizontal,
             left_arm_switch, right_arm_switch, left_mode_switch, right_mode_switch,
      input  ready
   );
   modport sink (
      input  valid, left_vertical, left_horizontal, right_vertical, right_horizontal,
             left_arm_switch, right_arm_switch, left_mode_switch, right_mode_switch,
      output ready
   );
endinterface

>>> rtl/rstv_rsp_if.sv
// rstv_rsp_if: result channel carrying velocity commands and arming status.
// Depends on rstv_pkg.
`timescale 1ns / 1ps

interface rstv_rsp_if;
   logic              valid;
   logic              ready;
   rstv_pkg::vel_type linear_velocity;
   rstv_pkg::vel_type angular_velocity;
   logic              left_active;
   logic              right_active;
   logic              arm_conflict;

   modport source (
      output valid, linear_velocity, angular_velocity, left_active, right_active,
             arm_conflict,
      input  ready
   );
   modport sink (
      input  valid, linear_velocity, angular_velocity, left_active, right_active,
             arm_conflict,
      output ready
   );
endinterface

>>> rtl/rstv_csr.sv
// rstv_csr: configuration register file, write only.
// Depends on rstv_pkg.
`timescale 1ns / 1ps

module rstv_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rstv_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [rstv_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output rstv_pkg::cfg_type                   cfg
);

   rstv_pkg::cfg_type cfg_ff;
   rstv_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (rstv_pkg::csr_addr_type'(csr_addr))
            rstv_pkg::CSR_CHAN_MIN:
               cfg_in.chan_min = csr_wdata[rstv_pkg::CHAN_BITS-1:0];
            rstv_pkg::CSR_CHAN_MAX:
               cfg_in.chan_max = csr_wdata[rstv_pkg::CHAN_BITS-1:0];
            rstv_pkg::CSR_TOLERANCE:
               cfg_in.tolerance = csr_wdata[rstv_pkg::TOL_BITS-1:0];
            rstv_pkg::CSR_LINEAR_GAIN:
               cfg_in.linear_gain = $signed(csr_wdata[rstv_pkg::VEL_BITS-1:0]);
            rstv_pkg::CSR_LINEAR_OFFSET:
               cfg_in.linear_offset = $signed(csr_wdata[rstv_pkg::VEL_BITS-1:0]);
            rstv_pkg::CSR_ANGULAR_GAIN:
               cfg_in.angular_gain = $signed(csr_wdata[rstv_pkg::VEL_BITS-1:0]);
            rstv_pkg::CSR_ANGULAR_OFFSET:
               cfg_in.angular_offset = $signed(csr_wdata[rstv_pkg::VEL_BITS-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chan_min       <= rstv_pkg::RST_CHAN_MIN;
         cfg_ff.chan_max       <= rstv_pkg::RST_CHAN_MAX;
         cfg_ff.tolerance      <= rstv_pkg::RST_TOLERANCE;
         cfg_ff.linear_gain    <= rstv_pkg::RST_LINEAR_GAIN;
         cfg_ff.linear_offset  <= rstv_pkg::RST_LINEAR_OFFSET;
         cfg_ff.angular_gain   <= rstv_pkg::RST_ANGULAR_GAIN;
         cfg_ff.angular_offset <= rstv_pkg::RST_ANGULAR_OFFSET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/rstv_ctl.sv
// rstv_ctl: arming, window and mode decode for one frame.
// Depends on rstv_pkg.
`timescale 1ns / 1ps

module rstv_ctl (
   input  rstv_pkg::frame_type frame,
   input  rstv_pkg::cfg_type   cfg,
   output rstv_pkg::dec_type   dec
);

   localparam int CB = rstv_pkg::CHAN_BITS;

   function automatic logic in_win(rstv_pkg::chan_type x, rstv_pkg::chan_type c,
                                   rstv_pkg::tol_type tol);
      logic signed [CB+1:0] diff;
      logic [CB:0]          mag;
      diff = $signed({2'b00, x}) - $signed({2'b00, c});
      mag  = diff[CB+1] ? (CB+1)'(0) - diff[CB:0] : diff[CB:0];
      return mag <= (CB+1)'(tol);
   endfunction

   logic signed [CB:0] span;
   logic signed [CB:0] half;
   logic signed [CB:0] mid_full;
   rstv_pkg::chan_type mid;
   logic               larm, rarm, conflict, lstart, rstart, len, ren, lact, ract;
   rstv_pkg::chan_type mode;

   always_comb begin
      // (max - min) / 2 rounded toward zero
      span     = $signed({1'b0, cfg.chan_max}) - $signed({1'b0, cfg.chan_min});
      half     = (span + $signed({{CB{1'b0}}, span[CB]})) >>> 1;
      mid_full = $signed({1'b0, cfg.chan_min}) + half;
      mid      = mid_full[CB-1:0];

      larm     = frame.left_arm_switch == cfg.chan_max;
      rarm     = frame.right_arm_switch == cfg.chan_max;
      conflict = larm && rarm;
      lstart   = !conflict && larm;
      rstart   = !conflict && !lstart && rarm;
      len      = in_win(frame.left_vertical, cfg.chan_min, cfg.tolerance)
                 && in_win(frame.left_horizontal, cfg.chan_max, cfg.tolerance);
      ren      = in_win(frame.right_vertical, cfg.chan_min, cfg.tolerance)
                 && in_win(frame.right_horizontal, cfg.chan_min, cfg.tolerance);
      lact     = lstart && len;
      ract     = rstart && ren;
      mode     = lact ? frame.left_mode_switch : frame.right_mode_switch;

      dec.left_active  = lact;
      dec.right_active = ract;
      dec.arm_conflict = conflict;
      dec.vert_x       = lact ? frame.right_vertical : frame.left_vertical;
      dec.horiz_x      = lact ? frame.right_horizontal : frame.left_horizontal;

      // level order decides where levels coincide
      priority if (!(lact || ract)) begin
         dec.sel = rstv_pkg::SEL_ZERO;
      end else if (mode == cfg.chan_max) begin
         dec.sel = rstv_pkg::SEL_LINEAR;
      end else if (mode == mid) begin
         dec.sel = rstv_pkg::SEL_ANGULAR;
      end else if (mode == cfg.chan_min) begin
         dec.sel = rstv_pkg::SEL_BOTH;
      end else begin
         dec.sel = rstv_pkg::SEL_HOLD;
      end
   end

endmodule

>>> rtl/rstv_lin.sv
// rstv_lin: gain * x + offset with saturation to the signed 32-bit range.
// Depends on rstv_pkg.
`timescale 1ns / 1ps

module rstv_lin (
   input  rstv_pkg::chan_type x,
   input  rstv_pkg::vel_type  gain,
   input  rstv_pkg::vel_type  offset,
   output rstv_pkg::vel_type  y
);

   localparam int VB = rstv_pkg::VEL_BITS;
   localparam int PW = VB + rstv_pkg::CHAN_BITS + 1;

   logic signed [PW-1:0] prod;
   logic signed [PW:0]   sum;
   logic [PW-VB+1:0]     top;

   always_comb begin
      prod = PW'($signed({1'b0, x})) * PW'(gain);
      sum  = (PW+1)'(prod) + (PW+1)'(offset);
      top  = sum[PW:VB-1];
      if ((top == '0) || (top == '1)) begin
         y = sum[VB-1:0];
      end else if (sum[PW]) begin
         y = {1'b1, {(VB-1){1'b0}}};
      end else begin
         y = {1'b0, {(VB-1){1'b1}}};
      end
   end

endmodule

>>> rtl/rc_sticks_to_velocity_top.sv
// rc_sticks_to_velocity_top: frame input register, decode and mapping logic,
// result register. Depends on rstv_pkg, rstv_req_if, rstv_rsp_if, rstv_csr,
// rstv_ctl, rstv_lin.
//
//   channel | dir | transfer
//   req     | in  | one RC frame, eight pulse widths
//   rsp     | out | linear/angular command, active flags, conflict
//   csr     | in  | register write, index and data, no wait
//
// Two register stages: a frame is captured, then mapped and stored in the
// result register; one frame per cycle sustained while the result stage is
// not stalled by rsp.ready held low.
// Reset clears both stages and the held commands; registers take reset values.
// A stalled result stage backs up into the input stage, which keeps taking a
// frame as long as the following stage can move.
`timescale 1ns / 1ps

module rc_sticks_to_velocity_top (
   input  logic                                clock,
   input  logic                                reset,
   rstv_req_if.sink                            req,
   rstv_rsp_if.source                          rsp,
   input  logic                                csr_we,
   input  logic [rstv_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [rstv_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   rstv_pkg::cfg_type   cfg;
   rstv_pkg::frame_type frame_ff;
   rstv_pkg::frame_type frame_in;
   rstv_pkg::dec_type   dec;
   rstv_pkg::vel_type   lin_y, ang_y;
   rstv_pkg::vel_type   held_lin_ff, held_lin_in, held_ang_ff, held_ang_in;
   logic                s1_vld_ff, s1_vld_in;
   logic                out_vld_ff, out_vld_in;
   logic [2:0]          flags_ff, flags_in;
   logic                out_go, s1_go, req_go;

   rstv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rstv_ctl u_ctl (
      .frame (frame_ff),
      .cfg   (cfg),
      .dec   (dec)
   );

   rstv_lin u_lin_linear (
      .x      (dec.vert_x),
      .gain   (cfg.linear_gain),
      .offset (cfg.linear_offset),
      .y      (lin_y)
   );

   rstv_lin u_lin_angular (
      .x      (dec.horiz_x),
      .gain   (cfg.angular_gain),
      .offset (cfg.angular_offset),
      .y      (ang_y)
   );

   always_comb begin
      out_go     = !out_vld_ff || rsp.ready;
      s1_go      = s1_vld_ff && out_go;
      req_go     = req.valid && req.ready;
      out_vld_in = s1_go ? 1'b1 : (out_vld_ff && !rsp.ready);
      s1_vld_in  = req_go ? 1'b1 : (s1_vld_ff && !s1_go);

      frame_in = req_go ? rstv_pkg::frame_type'{
                             left_vertical:     req.left_vertical,
                             left_horizontal:   req.left_horizontal,
                             right_vertical:    req.right_vertical,
                             right_horizontal:  req.right_horizontal,
                             left_arm_switch:   req.left_arm_switch,
                             right_arm_switch:  req.right_arm_switch,
                             left_mode_switch:  req.left_mode_switch,
                             right_mode_switch: req.right_mode_switch}
                        : frame_ff;

      held_lin_in = held_lin_ff;
      held_ang_in = held_ang_ff;
      flags_in    = flags_ff;
      if (s1_go) begin
         flags_in = {dec.left_active, dec.right_active, dec.arm_conflict};
         unique case (dec.sel)
            rstv_pkg::SEL_ZERO: begin
               held_lin_in = '0;
               held_ang_in = '0;
            end
            rstv_pkg::SEL_LINEAR: begin
               held_lin_in = lin_y;
               held_ang_in = '0;
            end
            rstv_pkg::SEL_ANGULAR: begin
               held_lin_in = '0;
               held_ang_in = ang_y;
            end
            rstv_pkg::SEL_BOTH: begin
               held_lin_in = lin_y;
               held_ang_in = ang_y;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         held_lin_ff <= '0;
         held_ang_ff <= '0;
      end else begin
         s1_vld_ff   <= s1_vld_in;
         out_vld_ff  <= out_vld_in;
         held_lin_ff <= held_lin_in;
         held_ang_ff <= held_ang_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      flags_ff <= flags_in;
   end

   assign req.ready            = !s1_vld_ff || out_go;
   assign rsp.valid            = out_vld_ff;
   assign rsp.linear_velocity  = held_lin_ff;
   assign rsp.angular_velocity = held_ang_ff;
   assign rsp.left_active      = flags_ff[2];
   assign rsp.right_active     = flags_ff[1];
   assign rsp.arm_conflict     = flags_ff[0];

`ifndef NO_ASSERTIONS
   a_conflict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.arm_conflict |-> rsp.linear_velocity == '0
                                        && rsp.angular_velocity == '0)
      else $error("conflict result carries nonzero command");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $countones({rsp.left_active, rsp.right_active, rsp.arm_conflict}) <= 1)
      else $error("more than one arming status set");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.left_active && !rsp.right_active
      |-> rsp.linear_velocity == '0 && rsp.angular_velocity == '0)
      else $error("inactive result carries nonzero command");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && out_vld_ff && !rsp.ready |-> !req.ready)
      else $error("input taken while both stages are blocked");
`endif

endmodule
